// ----- rtl/core/ic_pkg.sv -----
// Interrupt coalescer package: sizes, register indexes, command and kind codes,
// and the configuration bundle shared by the config block and the top level.
// No dependencies.
`default_nettype none

package ic_pkg;

    localparam int NUM_VECTORS = 32;
    localparam int VEC_W       = $clog2(NUM_VECTORS);
    localparam int COUNT_W     = 8;
    localparam int TICK_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int KIND_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGG_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

    // interrupt mode and result kind codes (same encoding)
    localparam logic [KIND_W-1:0] KIND_MSIX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MSI  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

    // request command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] threshold;
        logic [COUNT_W-1:0] agg_time;
        logic [KIND_W-1:0]  kind;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/ic_req_if.sv -----
// Request channel of the interrupt coalescer: completion events and ticks.
// Depends on ic_pkg.
`default_nettype none

interface ic_req_if
    import ic_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [VEC_W-1:0] vector;
    logic             admin;

    modport source (output valid, output cmd, output vector, output admin, input ready);
    modport sink   (input valid, input cmd, input vector, input admin, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ic_irq_if.sv -----
// Interrupt channel of the interrupt coalescer: raised interrupts with vector, kind and last flag.
// Depends on ic_pkg.
`default_nettype none

interface ic_irq_if
    import ic_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [VEC_W-1:0]  irq_vector;
    logic [KIND_W-1:0] irq_kind;
    logic              last;

    modport source (output valid, output irq_vector, output irq_kind, output last, input ready);
    modport sink   (input valid, input irq_vector, input irq_kind, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ic_cfg_regs.sv -----
// Configuration registers of the interrupt coalescer with mode-to-kind decode.
// Depends on ic_pkg.
`default_nettype none

module ic_cfg_regs
    import ic_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [CFG_IDX_W-1:0]  i_idx,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    logic [COUNT_W-1:0] r_threshold;
    logic [COUNT_W-1:0] r_agg_time;
    logic [KIND_W-1:0]  r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_agg_time  <= '0;
            r_mode      <= KIND_PIN;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_THRESHOLD: r_threshold <= i_data[COUNT_W-1:0];
                CFG_AGG_TIME:  r_agg_time  <= i_data[COUNT_W-1:0];
                CFG_MODE:      r_mode      <= i_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    // mode 3 falls back to the pin interrupt
    always_comb begin
        o_cfg.threshold = r_threshold;
        o_cfg.agg_time  = r_agg_time;
        unique case (r_mode)
            KIND_MSIX: o_cfg.kind = KIND_MSIX;
            KIND_MSI:  o_cfg.kind = KIND_MSI;
            default:   o_cfg.kind = KIND_PIN;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ic_count_ram.sv -----
// Per-vector event count memory: one write port, one read port, registered read.
// Depends on ic_pkg.
`default_nettype none

module ic_count_ram
    import ic_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [VEC_W-1:0]   i_waddr,
    input  wire logic [COUNT_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [VEC_W-1:0]   i_raddr,
    output logic      [COUNT_W-1:0] o_rdata
);

    logic [COUNT_W-1:0] r_mem [NUM_VECTORS];
    logic [COUNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/interrupt_coalescer.sv -----
// Interrupt coalescer top level: request FSM, nonzero flags, tick counter, output register.
// Depends on ic_pkg, ic_req_if, ic_irq_if, ic_cfg_regs and ic_count_ram.
`default_nettype none

// Per-vector interrupt coalescing. Each request is a completion event or a
// 100 us tick. A non-admin completion bumps its vector's count (saturating at
// 255); reaching coalesce_threshold clears the count and raises one interrupt.
// Admin completions raise an interrupt at once. After aggregation_time+1 ticks
// a flush raises one interrupt per vector with a nonzero count, in ascending
// order, with last set on the final one, and clears those counts. irq_kind
// follows interrupt_mode (mode 3 acts as the pin interrupt). Requests are handled
// one at a time: a completion's count is read from the RAM on accept (registered
// read) and written back, or its flag cleared, in ST_EXEC; a tick bumps the tick
// counter there. A flushing tick then walks the vector indexes from 0 up to the
// highest nonzero vector. Downstream stalls hold the FSM only when a new interrupt
// meets a still-full output register; a request is accepted while the last
// interrupt still waits. Counts live in a 32-entry RAM; a per-vector nonzero flag
// (cleared by reset) masks stale RAM contents, so there is no clearing pass after
// reset. Config writes belong to idle periods.

module interrupt_coalescer
    import ic_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ic_req_if.sink                     i_req,
    ic_irq_if.source                   o_irq
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    t_cfg cfg;

    t_state             r_state,     n_state;
    logic [NUM_VECTORS-1:0] r_flag,  n_flag;   // count nonzero
    logic [TICK_W-1:0]  r_tick,      n_tick;
    logic [VEC_W-1:0]   r_idx,       n_idx;    // flush walk pointer
    logic               r_cmd,       n_cmd;
    logic [VEC_W-1:0]   r_vec,       n_vec;
    logic               r_admin,     n_admin;
    logic               r_out_valid, n_out_valid;
    logic [VEC_W-1:0]   r_out_vec,   n_out_vec;
    logic [KIND_W-1:0]  r_out_kind,  n_out_kind;
    logic               r_out_last,  n_out_last;

    logic               req_acc;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] inc_count;
    logic               fire;
    logic [TICK_W-1:0]  tick_inc;
    logic [TICK_W-1:0]  tick_lim;
    logic [NUM_VECTORS-1:0] above_mask;
    logic               emit;

    ic_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // read issued on accept, write back in ST_EXEC
    ic_count_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_vec),
        .i_wdata (inc_count),
        .i_re    (ram_re),
        .i_raddr (i_req.vector),
        .o_rdata (ram_rdata)
    );

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_irq.ready;
    assign ram_re      = req_acc;

    // an unflagged entry reads as zero whatever the RAM holds
    assign cur_count = r_flag[r_vec] ? ram_rdata : '0;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
    assign fire      = (inc_count >= cfg.threshold);

    assign tick_inc  = r_tick + TICK_W'(1);
    assign tick_lim  = {1'b0, cfg.agg_time} + TICK_W'(1);

    // vectors above the flush pointer
    assign above_mask = ({NUM_VECTORS{1'b1}} << r_idx) << 1;

    always_comb begin
        n_state     = r_state;
        n_flag      = r_flag;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_vec       = r_vec;
        n_admin     = r_admin;
        n_out_valid = r_out_valid && !o_irq.ready;
        n_out_vec   = r_out_vec;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        emit        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_cmd   = i_req.cmd;
                    n_vec   = i_req.vector;
                    n_admin = i_req.admin;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd == CMD_TICK) begin
                    if (tick_inc < tick_lim) begin
                        n_tick  = tick_inc;
                        n_state = ST_IDLE;
                    end else begin
                        n_tick  = '0;
                        n_idx   = '0;
                        n_state = (r_flag != '0) ? ST_FLUSH : ST_IDLE;
                    end
                end else if (r_admin || fire) begin
                    // wait here until the output register can take it
                    if (out_free) begin
                        emit       = 1'b1;
                        n_out_vec  = r_vec;
                        n_out_last = 1'b1;
                        if (!r_admin) begin
                            n_flag[r_vec] = 1'b0;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    ram_we        = 1'b1;
                    n_flag[r_vec] = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!r_flag[r_idx]) begin
                    n_idx = r_idx + VEC_W'(1);
                end else if (out_free) begin
                    emit          = 1'b1;
                    n_out_vec     = r_idx;
                    n_out_last    = ((r_flag & above_mask) == '0);
                    n_flag[r_idx] = 1'b0;
                    n_idx         = r_idx + VEC_W'(1);
                end
                if (n_flag == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = cfg.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_flag      <= '0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_tick      <= n_tick;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_vec      <= n_vec;
        r_admin    <= n_admin;
        r_out_vec  <= n_out_vec;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_irq.valid      = r_out_valid;
    assign o_irq.irq_vector = r_out_vec;
    assign o_irq.irq_kind   = r_out_kind;
    assign o_irq.last       = r_out_last;

    // a flush walk only runs while some count is nonzero
    a_flush_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_flag != '0)
        else $error("flush walk with no nonzero vector");

    // the interval counter never runs past the longest interval
    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= TICK_W'(256))
        else $error("tick counter out of range");

    // a flushed vector is cleared once its interrupt is raised
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && emit) |=> !r_flag[$past(r_idx)])
        else $error("flushed vector still flagged");

    // the reserved mode code never reaches the interrupt kind
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_kind != KIND_RSVD)
        else $error("reserved interrupt kind raised");

endmodule

`default_nettype wire

// ----- verif/tb_interrupt_coalescer.sv -----
// Testbench for interrupt_coalescer: directed and random completion/tick traffic with
// random idling on both channels, checked against an in-bench coalescing predictor.
// Depends on ic_pkg, ic_req_if, ic_irq_if and the interrupt_coalescer RTL.
`default_nettype none

module tb_interrupt_coalescer;
    import ic_pkg::*;

    // index past the end of the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // worst flush walks all 32 vectors plus the RMW; covers requests that raise nothing
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_GAP       = 11;
    localparam int RAND_PHASE    = 28;   // requests per random phase, four phases
    localparam int RUN_LIMIT     = 1_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: coalescing predictor plus the queue of irqs still owed
    // ------------------------------------------------------------------
    class coalesce_scoreboard;
        typedef struct {
            logic [VEC_W-1:0]  vec;
            logic [KIND_W-1:0] kind;
            logic              last;
        } t_irq;

        t_cfg               cfg;
        logic [COUNT_W-1:0] counts [NUM_VECTORS];
        logic [TICK_W-1:0]  ticks;
        t_irq               pending_irqs [$];
        int unsigned        mismatches;

        function new();
            cfg.threshold = '0;
            cfg.agg_time  = '0;
            cfg.kind      = KIND_PIN;
            foreach (counts[i]) counts[i] = '0;
            ticks      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: cfg.threshold = data[COUNT_W-1:0];
                CFG_AGG_TIME:  cfg.agg_time  = data[COUNT_W-1:0];
                CFG_MODE:      cfg.kind      = data[KIND_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_irq(logic [VEC_W-1:0] vec, logic last);
            t_irq irq;
            irq.vec  = vec;
            irq.last = last;
            case (cfg.kind)
                KIND_MSIX: irq.kind = KIND_MSIX;
                KIND_MSI:  irq.kind = KIND_MSI;
                default:   irq.kind = KIND_PIN;   // mode 3 falls back to the pin
            endcase
            pending_irqs.push_back(irq);
        endfunction

        function void note_request(logic cmd, logic [VEC_W-1:0] vec, logic admin);
            logic [COUNT_W-1:0] cnt;
            int                 top;
            if (cmd == CMD_EVENT) begin
                if (!admin) begin
                    cnt = counts[vec];
                    if (cnt != COUNT_MAX) cnt++;
                    if (cnt < cfg.threshold) begin
                        counts[vec] = cnt;
                        return;
                    end
                    counts[vec] = '0;
                end
                push_irq(vec, 1'b1);
                return;
            end
            ticks++;
            if (int'(ticks) < int'(cfg.agg_time) + 1) return;
            ticks = '0;
            top = -1;
            for (int i = 0; i < NUM_VECTORS; i++)
                if (counts[i] != '0) top = i;
            for (int i = 0; i <= top; i++) begin
                if (counts[i] != '0) begin
                    push_irq(VEC_W'(i), i == top);
                    counts[i] = '0;
                end
            end
        endfunction

        function void check_irq(logic [VEC_W-1:0] vec, logic [KIND_W-1:0] kind, logic last);
            t_irq owed;
            if (pending_irqs.size() == 0) begin
                $error("unexpected irq: vector %0d kind %0d last %0b", vec, kind, last);
                mismatches++;
                return;
            end
            owed = pending_irqs.pop_front();
            if (vec !== owed.vec) begin
                $error("irq_vector: expected %0d, got %0d", owed.vec, vec);
                mismatches++;
            end
            if (kind !== owed.kind) begin
                $error("irq_kind: expected %0d, got %0d", owed.kind, kind);
                mismatches++;
            end
            if (last !== owed.last) begin
                $error("last: expected %0b, got %0b", owed.last, last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return pending_irqs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ic_req_if req_if ();
    ic_irq_if irq_if ();

    interrupt_coalescer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_irq      (irq_if.source)
    );

    coalesce_scoreboard sb = new();

    // idling switches, redrawn in stretches by the stimulus
    bit src_gaps;
    bit sink_stalls;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the DUT hangs
    initial begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: all sampling at the rising edge, before the DUT's updates land
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.cmd, req_if.vector, req_if.admin);
            if (irq_if.valid && irq_if.ready)
                sb.check_irq(irq_if.irq_vector, irq_if.irq_kind, irq_if.last);
        end
    end

    // ------------------------------------------------------------------
    // irq sink: per irq, optionally hold ready low for a random stall, then take it
    // ------------------------------------------------------------------
    initial begin : irq_sink
        int unsigned stall;
        irq_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = sink_stalls ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                irq_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            irq_if.ready <= 1'b1;
            // ready is high for the whole wait, so valid alone marks the handshake
            do @(posedge i_clk); while (!irq_if.valid);
        end
    end

    // ------------------------------------------------------------------
    // Request driver tasks
    // ------------------------------------------------------------------

    // One request; valid stays high into the next request when no gap is drawn.
    task automatic send_request(input logic cmd, input logic [VEC_W-1:0] vec,
                                input logic admin);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.cmd    <= cmd;
        req_if.vector <= vec;
        req_if.admin  <= admin;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stop requesting until every owed irq arrived; with settle, also let the
    // DUT finish requests that raise nothing (count bumps, empty flushes).
    task automatic wait_quiet(input bit settle);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Full register set plus one write past the list, only while idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] agg,
                             input logic [CFG_DATA_W-1:0] mode);
        wait_quiet(1'b1);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AGG_TIME;
        i_cfg_data <= agg;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly completions, half of them on a few low vectors so counts build up
    // and coalesce; some admin events; ~15% ticks with junk in the ignored fields.
    task automatic send_random();
        int unsigned      roll;
        logic [VEC_W-1:0] vec;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 1) != 0)
            vec = VEC_W'($urandom_range(0, 3));
        else
            vec = VEC_W'($urandom_range(0, NUM_VECTORS - 1));
        if (roll < 15)
            send_request(CMD_TICK, VEC_W'($urandom), 1'($urandom));
        else
            send_request(CMD_EVENT, vec, roll < 30);
    endtask

    // Random phase of a fixed number of requests.
    task automatic run_phase(input int unsigned n_req);
        int unsigned k;
        k = 0;
        while (k < n_req) begin
            // new idling mix every 16 requests, including none at all
            if (k % 16 == 0) begin
                src_gaps    = $urandom_range(0, 1);
                sink_stalls = $urandom_range(0, 1);
            end
            // hold back now and then until the DUT has delivered everything
            if (k == n_req / 3 || $urandom_range(0, 29) == 0)
                wait_quiet(1'b0);
            send_random();
            k++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_THRESHOLD;
        i_cfg_data    <= '0;
        req_if.valid  <= 1'b0;
        req_if.cmd    <= CMD_EVENT;
        req_if.vector <= '0;
        req_if.admin  <= 1'b0;
        src_gaps       = 1'b0;
        sink_stalls    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset config: threshold 0 fires every event, one tick per interval, pin kind
        send_request(CMD_EVENT, VEC_W'(0), 1'b0);
        send_request(CMD_EVENT, VEC_W'(NUM_VECTORS - 1), 1'b1);
        send_request(CMD_TICK, VEC_W'(NUM_VECTORS - 1), 1'b1);   // empty flush

        // threshold 2, two-tick interval, MSI-X
        configure(8'd2, 8'd1, CFG_DATA_W'(KIND_MSIX));
        send_request(CMD_EVENT, VEC_W'(0), 1'b0);
        send_request(CMD_EVENT, VEC_W'(NUM_VECTORS - 1), 1'b0);
        send_request(CMD_EVENT, VEC_W'(5), 1'b0);
        send_request(CMD_EVENT, VEC_W'(5), 1'b0);    // reaches threshold
        send_request(CMD_EVENT, VEC_W'(7), 1'b1);    // admin bypasses counting
        send_request(CMD_TICK, VEC_W'(0), 1'b0);     // interval not done yet
        send_request(CMD_TICK, VEC_W'(0), 1'b0);     // flush: vectors 0 then 31
        send_request(CMD_TICK, VEC_W'(0), 1'b0);
        send_request(CMD_TICK, VEC_W'(0), 1'b0);     // empty flush

        // largest threshold and interval; all-ones mode data leaves mode 3 (pin)
        configure(8'd255, 8'd255, {CFG_DATA_W{1'b1}});
        send_request(CMD_EVENT, VEC_W'(3), 1'b0);
        send_request(CMD_EVENT, VEC_W'(3), 1'b0);
        send_request(CMD_EVENT, VEC_W'(16), 1'b0);
        send_request(CMD_EVENT, VEC_W'(9), 1'b1);
        send_request(CMD_TICK, VEC_W'(0), 1'b0);
        send_request(CMD_TICK, VEC_W'(0), 1'b0);
        send_request(CMD_TICK, VEC_W'(0), 1'b0);

        // interval shortened below ticks already counted: next tick flushes 3, 16
        configure(8'd4, 8'd1, CFG_DATA_W'(KIND_MSI));
        send_request(CMD_TICK, VEC_W'(0), 1'b0);

        // --- random ---
        configure(8'd3, 8'd2, CFG_DATA_W'(KIND_MSIX));
        run_phase(RAND_PHASE);
        // counts pile up here and get flushed wholesale in the next phase
        configure(8'd255, 8'd255, {CFG_DATA_W{1'b1}});
        run_phase(RAND_PHASE);
        configure(8'd0, 8'd0, CFG_DATA_W'(KIND_MSI));
        run_phase(RAND_PHASE);
        configure(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(0, 4)),
                  CFG_DATA_W'(KIND_PIN));
        run_phase(RAND_PHASE);

        // --- wrap up: drain, give the DUT time to emit anything stray ---
        wait_quiet(1'b1);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- interrupt_coalescer.f -----
rtl/core/ic_pkg.sv
rtl/core/ic_req_if.sv
rtl/core/ic_irq_if.sv
rtl/core/ic_cfg_regs.sv
rtl/core/ic_count_ram.sv
rtl/core/interrupt_coalescer.sv
verif/tb_interrupt_coalescer.sv
